/* sv/psc_pkg.sv */
// shared types, codes and the micro-program of the compensation sequencer
package psc_pkg;

    // operation codes carried by each input transfer
    localparam logic OP_TEMPERATURE = 1'b0;
    localparam logic OP_PRESSURE    = 1'b1;

    localparam int unsigned NUM_CAL_REGS = 4;
    localparam int unsigned PC_W         = 6;

    // calibration register indexes
    localparam logic [1:0] REG_CAL_ONE   = 2'd0;
    localparam logic [1:0] REG_CAL_TWO   = 2'd1;
    localparam logic [1:0] REG_CAL_THREE = 2'd2;
    localparam logic [1:0] REG_CAL_FOUR  = 2'd3;

    // general register indexes of the datapath
    localparam logic [1:0] G0 = 2'd0;
    localparam logic [1:0] G1 = 2'd1;
    localparam logic [1:0] G2 = 2'd2;
    localparam logic [1:0] G3 = 2'd3;

    typedef enum logic [3:0] {
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_DIV,
        UOP_JNEG,
        UOP_JMP,
        UOP_JOP,
        UOP_FINT,
        UOP_FINP
    } t_uop;

    typedef enum logic [3:0] {
        SRC_G0,
        SRC_G1,
        SRC_G2,
        SRC_G3,
        SRC_IMM,
        SRC_TRAW,
        SRC_PRAW,
        SRC_SENS,
        SRC_OFF,
        SRC_TCS,
        SRC_TCO,
        SRC_TREF,
        SRC_TSENS
    } t_src;

    typedef struct packed {
        t_uop            uop;
        logic [1:0]      dst;
        t_src            sa;
        t_src            sb;
        logic [3:0]      sh;
        logic [15:0]     imm;
        logic [PC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic [12:0] sens;
        logic [12:0] off;
        logic [9:0]  tcs;
        logic [8:0]  tco;
        logic [11:0] tref;
        logic [6:0]  tsens;
    } t_coef;

    typedef struct packed {
        logic        start;
        logic        pressure;
        logic [15:0] raw;
    } t_eng_req;

    typedef struct packed {
        logic               done;
        logic               pressure;
        logic signed [31:0] value;
    } t_eng_rsp;

    // program entry points
    localparam logic [PC_W-1:0] PC_CORR_POS = 6'd9;
    localparam logic [PC_W-1:0] PC_DT2      = 6'd10;
    localparam logic [PC_W-1:0] PC_PRESSURE = 6'd17;

    function automatic t_uword mk(t_uop uop, logic [1:0] dst, t_src sa, t_src sb,
                                  logic [3:0] sh, logic [15:0] imm,
                                  logic [PC_W-1:0] tgt);
        t_uword w;
        w.uop = uop;
        w.dst = dst;
        w.sa  = sa;
        w.sb  = sb;
        w.sh  = sh;
        w.imm = imm;
        w.tgt = tgt;
        return w;
    endfunction

    // control store: g1 ends up holding the corrected temperature difference
    function automatic t_uword uprog(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            6'd0:  w = mk(UOP_MUL,  G0, SRC_TREF, SRC_IMM,  4'd0,  16'd8,     '0);
            6'd1:  w = mk(UOP_ADD,  G0, SRC_G0,   SRC_IMM,  4'd0,  16'd10000, '0);
            6'd2:  w = mk(UOP_SUB,  G1, SRC_TRAW, SRC_G0,   4'd0,  16'd0,     '0);
            6'd3:  w = mk(UOP_DIV,  G2, SRC_G1,   SRC_IMM,  4'd7,  16'd0,     '0);
            6'd4:  w = mk(UOP_MUL,  G2, SRC_G2,   SRC_G1,   4'd0,  16'd0,     '0);
            6'd5:  w = mk(UOP_DIV,  G2, SRC_G2,   SRC_IMM,  4'd7,  16'd0,     '0);
            6'd6:  w = mk(UOP_JNEG, G0, SRC_G1,   SRC_IMM,  4'd0,  16'd0,     PC_CORR_POS);
            6'd7:  w = mk(UOP_DIV,  G2, SRC_G2,   SRC_IMM,  4'd3,  16'd0,     '0);
            6'd8:  w = mk(UOP_JMP,  G0, SRC_G0,   SRC_IMM,  4'd0,  16'd0,     PC_DT2);
            // negative difference takes the stronger correction
            6'd9:  w = mk(UOP_DIV,  G2, SRC_G2,   SRC_IMM,  4'd1,  16'd0,     '0);
            6'd10: w = mk(UOP_SUB,  G1, SRC_G1,   SRC_G2,   4'd0,  16'd0,     '0);
            6'd11: w = mk(UOP_JOP,  G0, SRC_G0,   SRC_IMM,  4'd0,  16'd0,     PC_PRESSURE);
            6'd12: w = mk(UOP_ADD,  G0, SRC_TSENS, SRC_IMM, 4'd0,  16'd100,   '0);
            6'd13: w = mk(UOP_MUL,  G0, SRC_G1,   SRC_G0,   4'd0,  16'd0,     '0);
            6'd14: w = mk(UOP_DIV,  G0, SRC_G0,   SRC_IMM,  4'd11, 16'd0,     '0);
            6'd15: w = mk(UOP_ADD,  G0, SRC_G0,   SRC_IMM,  4'd0,  16'd200,   '0);
            6'd16: w = mk(UOP_FINT, G0, SRC_G0,   SRC_IMM,  4'd0,  16'd0,     '0);
            6'd17: w = mk(UOP_SUB,  G0, SRC_TCO,  SRC_IMM,  4'd0,  16'd250,   '0);
            6'd18: w = mk(UOP_MUL,  G0, SRC_G0,   SRC_G1,   4'd0,  16'd0,     '0);
            6'd19: w = mk(UOP_DIV,  G0, SRC_G0,   SRC_IMM,  4'd12, 16'd0,     '0);
            6'd20: w = mk(UOP_ADD,  G0, SRC_G0,   SRC_OFF,  4'd0,  16'd0,     '0);
            6'd21: w = mk(UOP_ADD,  G0, SRC_G0,   SRC_IMM,  4'd0,  16'd10000, '0);
            6'd22: w = mk(UOP_DIV,  G2, SRC_SENS, SRC_IMM,  4'd1,  16'd0,     '0);
            6'd23: w = mk(UOP_ADD,  G3, SRC_TCS,  SRC_IMM,  4'd0,  16'd200,   '0);
            6'd24: w = mk(UOP_MUL,  G3, SRC_G3,   SRC_G1,   4'd0,  16'd0,     '0);
            6'd25: w = mk(UOP_DIV,  G3, SRC_G3,   SRC_IMM,  4'd13, 16'd0,     '0);
            6'd26: w = mk(UOP_ADD,  G2, SRC_G2,   SRC_G3,   4'd0,  16'd0,     '0);
            6'd27: w = mk(UOP_ADD,  G2, SRC_G2,   SRC_IMM,  4'd0,  16'd3000,  '0);
            6'd28: w = mk(UOP_SUB,  G3, SRC_PRAW, SRC_G0,   4'd0,  16'd0,     '0);
            6'd29: w = mk(UOP_MUL,  G3, SRC_G2,   SRC_G3,   4'd0,  16'd0,     '0);
            6'd30: w = mk(UOP_DIV,  G3, SRC_G3,   SRC_IMM,  4'd12, 16'd0,     '0);
            6'd31: w = mk(UOP_ADD,  G3, SRC_G3,   SRC_IMM,  4'd0,  16'd1000,  '0);
            6'd32: w = mk(UOP_FINP, G0, SRC_G3,   SRC_IMM,  4'd0,  16'd0,     '0);
            default: w = mk(UOP_FINT, G0, SRC_G0, SRC_IMM,  4'd0,  16'd0,     '0);
        endcase
        return w;
    endfunction

endpackage

/* sv/psc_engine.sv */
// micro-sequenced datapath: step counter, control store, four registers, one alu
module psc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psc_pkg::t_eng_req i_req,
    input  psc_pkg::t_coef    i_coef,
    input  logic [15:0]       i_temp_raw,
    input  logic              i_hold,
    output psc_pkg::t_eng_rsp o_rsp
);

    logic                        r_run;
    logic [psc_pkg::PC_W-1:0]    r_pc;
    logic                        r_pressure;
    logic [15:0]                 r_raw;
    logic signed [31:0]          r_g0;
    logic signed [31:0]          r_g1;
    logic signed [31:0]          r_g2;
    logic signed [31:0]          r_g3;

    psc_pkg::t_uword             w_word;
    logic signed [31:0]          w_a;
    logic signed [31:0]          w_b;
    logic signed [31:0]          w_imm;
    logic [31:0]                 w_mask;
    logic signed [31:0]          w_biased;
    logic signed [31:0]          w_alu;
    logic                        w_is_alu;
    logic                        w_is_fin;
    logic [psc_pkg::PC_W-1:0]    w_pc_inc;

    assign w_word   = psc_pkg::uprog(r_pc);
    assign w_imm    = {{16{w_word.imm[15]}}, w_word.imm};
    assign w_pc_inc = r_pc + 1'b1;

    always_comb begin
        case (w_word.sa)
            psc_pkg::SRC_G0:    w_a = r_g0;
            psc_pkg::SRC_G1:    w_a = r_g1;
            psc_pkg::SRC_G2:    w_a = r_g2;
            psc_pkg::SRC_G3:    w_a = r_g3;
            psc_pkg::SRC_IMM:   w_a = w_imm;
            psc_pkg::SRC_TRAW:  w_a = {16'd0, i_temp_raw};
            psc_pkg::SRC_PRAW:  w_a = {16'd0, r_raw};
            psc_pkg::SRC_SENS:  w_a = {19'd0, i_coef.sens};
            psc_pkg::SRC_OFF:   w_a = {19'd0, i_coef.off};
            psc_pkg::SRC_TCS:   w_a = {22'd0, i_coef.tcs};
            psc_pkg::SRC_TCO:   w_a = {23'd0, i_coef.tco};
            psc_pkg::SRC_TREF:  w_a = {20'd0, i_coef.tref};
            psc_pkg::SRC_TSENS: w_a = {25'd0, i_coef.tsens};
            default:            w_a = '0;
        endcase
    end

    always_comb begin
        case (w_word.sb)
            psc_pkg::SRC_G0:    w_b = r_g0;
            psc_pkg::SRC_G1:    w_b = r_g1;
            psc_pkg::SRC_G2:    w_b = r_g2;
            psc_pkg::SRC_G3:    w_b = r_g3;
            psc_pkg::SRC_IMM:   w_b = w_imm;
            psc_pkg::SRC_TRAW:  w_b = {16'd0, i_temp_raw};
            psc_pkg::SRC_PRAW:  w_b = {16'd0, r_raw};
            psc_pkg::SRC_SENS:  w_b = {19'd0, i_coef.sens};
            psc_pkg::SRC_OFF:   w_b = {19'd0, i_coef.off};
            psc_pkg::SRC_TCS:   w_b = {22'd0, i_coef.tcs};
            psc_pkg::SRC_TCO:   w_b = {23'd0, i_coef.tco};
            psc_pkg::SRC_TREF:  w_b = {20'd0, i_coef.tref};
            psc_pkg::SRC_TSENS: w_b = {25'd0, i_coef.tsens};
            default:            w_b = '0;
        endcase
    end

    // division by a power of two rounds toward zero: bias negatives before the shift
    assign w_mask   = (32'd1 << w_word.sh) - 32'd1;
    assign w_biased = w_a + (w_a[31] ? signed'(w_mask) : 32'sd0);

    always_comb begin
        w_is_alu = 1'b0;
        w_is_fin = 1'b0;
        w_alu    = '0;
        case (w_word.uop)
            psc_pkg::UOP_ADD: begin
                w_is_alu = 1'b1;
                w_alu    = w_a + w_b;
            end
            psc_pkg::UOP_SUB: begin
                w_is_alu = 1'b1;
                w_alu    = w_a - w_b;
            end
            psc_pkg::UOP_MUL: begin
                w_is_alu = 1'b1;
                w_alu    = w_a * w_b;
            end
            psc_pkg::UOP_DIV: begin
                w_is_alu = 1'b1;
                w_alu    = w_biased >>> w_word.sh;
            end
            psc_pkg::UOP_FINT, psc_pkg::UOP_FINP: begin
                w_is_fin = 1'b1;
            end
            default: begin
                w_alu = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (i_req.start) begin
            r_run <= 1'b1;
            r_pc  <= '0;
        end else if (r_run) begin
            case (w_word.uop)
                psc_pkg::UOP_ADD, psc_pkg::UOP_SUB,
                psc_pkg::UOP_MUL, psc_pkg::UOP_DIV: begin
                    r_pc <= w_pc_inc;
                end
                psc_pkg::UOP_JNEG: begin
                    r_pc <= w_a[31] ? w_word.tgt : w_pc_inc;
                end
                psc_pkg::UOP_JMP: begin
                    r_pc <= w_word.tgt;
                end
                psc_pkg::UOP_JOP: begin
                    r_pc <= r_pressure ? w_word.tgt : w_pc_inc;
                end
                psc_pkg::UOP_FINT, psc_pkg::UOP_FINP: begin
                    if (!i_hold) begin
                        r_run <= 1'b0;
                    end
                end
                default: begin
                    r_run <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_pressure <= i_req.pressure;
            r_raw      <= i_req.raw;
        end
        if (r_run && w_is_alu) begin
            case (w_word.dst)
                psc_pkg::G0: r_g0 <= w_alu;
                psc_pkg::G1: r_g1 <= w_alu;
                psc_pkg::G2: r_g2 <= w_alu;
                psc_pkg::G3: r_g3 <= w_alu;
                default:     r_g0 <= w_alu;
            endcase
        end
    end

    assign o_rsp.done     = r_run && w_is_fin && !i_hold;
    assign o_rsp.pressure = r_pressure;
    assign o_rsp.value    = w_a;

endmodule

/* sv/pressure_sensor_compensation.sv */
// top level: calibration registers, input/output transfers and the compensation engine
//
// Barometric sensor second-order compensation. Write the four 16-bit
// calibration words over the register port at byte addresses 0, 4, 8 and 12
// before sending readings. Each input transfer carries an operation (0
// temperature, 1 pressure) and a raw conversion value; a temperature transfer
// also becomes the stored temperature reading that later pressure transfers
// use (zero after reset). Exactly one result follows each input. The work is
// done by a small micro-program that runs one step per cycle on a single
// shared add/shift/multiply unit, except that its final step waits while an
// earlier result is stalled in the output register; the program takes a
// shorter path when the stored reading lies below the reference temperature,
// and one reading is processed at a time. The next reading is accepted while an
// earlier result still waits in the output register.
module pressure_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_raw_reading,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_temperature_tenths,
    output logic [15:0] o_pressure_mbar,
    output logic        o_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]        r_cal [psc_pkg::NUM_CAL_REGS];
    logic [15:0]        r_temp_raw;
    logic               r_busy;
    logic               r_out_valid;
    logic signed [15:0] r_temperature;
    logic [15:0]        r_pressure;
    logic               r_oor;

    logic               w_in_xfer;
    logic               w_hold;
    logic               w_cfg_wr;
    logic [1:0]         w_idx;
    psc_pkg::t_coef     w_coef;
    psc_pkg::t_eng_req  w_req;
    psc_pkg::t_eng_rsp  w_rsp;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = {16'd0, r_cal[w_idx]};

    assign w_coef.sens  = r_cal[psc_pkg::REG_CAL_ONE][15:3];
    assign w_coef.off   = {r_cal[psc_pkg::REG_CAL_ONE][2:0], r_cal[psc_pkg::REG_CAL_TWO][15:6]};
    assign w_coef.tcs   = r_cal[psc_pkg::REG_CAL_THREE][15:6];
    assign w_coef.tco   = r_cal[psc_pkg::REG_CAL_FOUR][15:7];
    assign w_coef.tref  = {r_cal[psc_pkg::REG_CAL_TWO][5:0], r_cal[psc_pkg::REG_CAL_THREE][5:0]};
    assign w_coef.tsens = r_cal[psc_pkg::REG_CAL_FOUR][6:0];

    assign o_in_stall = r_busy;
    assign w_in_xfer  = i_in_valid && !r_busy;
    assign w_hold     = r_out_valid && i_out_stall;

    assign w_req.start    = w_in_xfer;
    assign w_req.pressure = (i_operation == psc_pkg::OP_PRESSURE);
    assign w_req.raw      = i_raw_reading;

    psc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_coef     (w_coef),
        .i_temp_raw (r_temp_raw),
        .i_hold     (w_hold),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psc_pkg::NUM_CAL_REGS; i++) begin
                r_cal[i] <= '0;
            end
            r_temp_raw  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cal[w_idx] <= pwdata[15:0];
            end
            if (w_in_xfer) begin
                r_busy <= 1'b1;
                if (i_operation == psc_pkg::OP_TEMPERATURE) begin
                    r_temp_raw <= i_raw_reading;
                end
            end else if (w_rsp.done) begin
                r_busy <= 1'b0;
            end
            if (w_rsp.done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: out of range when the 32-bit value does not fit its field
    always_ff @(posedge i_clk) begin
        if (w_rsp.done) begin
            if (w_rsp.pressure) begin
                r_temperature <= '0;
                r_pressure    <= w_rsp.value[15:0];
                r_oor         <= |w_rsp.value[31:16];
            end else begin
                r_temperature <= w_rsp.value[15:0];
                r_pressure    <= '0;
                r_oor         <= !((&w_rsp.value[31:15]) || !(|w_rsp.value[31:15]));
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_temperature_tenths = r_temperature;
    assign o_pressure_mbar      = r_pressure;
    assign o_out_of_range       = r_oor;

endmodule

/* sv/psc_checker.sv */
// port-level checker for the compensation block and its bind
module psc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_temperature_tenths,
    input logic [15:0] o_pressure_mbar
);

    // stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_temperature_tenths) && $stable(o_pressure_mbar))
        else $error("stalled result changed or dropped");

    // one reading at a time: an input transfer closes the input side
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a reading is in progress");

    // a result never appears the cycle right after its input transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    // only one of the two result fields carries a value
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_temperature_tenths != 16'd0) |-> o_pressure_mbar == 16'd0)
        else $error("both temperature and pressure fields set");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_temperature_tenths (o_temperature_tenths),
    .o_pressure_mbar      (o_pressure_mbar)
);
